// ===== src/dmfr_pkg.sv =====
// Shared types, constants and font functions for the digit matrix frame renderer.
package dmfr_pkg;

    typedef struct packed {
        logic       command;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [5:0] second_value;
        logic [7:0] humidity_value;
        logic [7:0] temperature_value;
    } t_item;

    typedef struct packed {
        logic       busy;
        logic       advance;
        logic [2:0] row;
        logic       last;
    } t_step;

    localparam logic       CMD_CLOCK   = 1'b0;
    localparam logic       CMD_CLIMATE = 1'b1;
    localparam logic [2:0] LAST_ROW    = 3'd7;
    localparam logic [2:0] DOT_ROW     = 3'd7;
    localparam logic [2:0] COLON_ROW_A = 3'd3;
    localparam logic [2:0] COLON_ROW_B = 3'd5;

    function automatic logic [3:0] f_div10(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] f_mod10(input logic [6:0] v);
        logic [3:0] q;
        logic [6:0] q10;
        q   = f_div10(v);
        q10 = 7'({3'd0, q} << 3) + 7'({3'd0, q} << 1);
        return 4'(v - q10);
    endfunction

    function automatic logic [6:0] f_mod100(input logic [7:0] v);
        logic [6:0] r;
        if (v >= 8'd200) begin
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            r = 7'(v - 8'd100);
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] f_glyph(input logic [3:0] digit, input logic [2:0] row);
        logic [14:0] g;
        logic [2:0]  r;
        case (digit)
            4'd0:    g = 15'b111_101_101_101_111;
            4'd1:    g = 15'b001_001_001_001_001;
            4'd2:    g = 15'b111_001_111_100_111;
            4'd3:    g = 15'b111_001_111_001_111;
            4'd4:    g = 15'b101_101_111_001_001;
            4'd5:    g = 15'b111_100_111_001_111;
            4'd6:    g = 15'b111_100_111_101_111;
            4'd7:    g = 15'b111_001_001_001_001;
            4'd8:    g = 15'b111_101_111_101_111;
            4'd9:    g = 15'b111_101_111_001_111;
            default: g = 15'd0;
        endcase
        case (row)
            3'd2:    r = g[14:12];
            3'd3:    r = g[11:9];
            3'd4:    r = g[8:6];
            3'd5:    r = g[5:3];
            3'd6:    r = g[2:0];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_degree(input logic [2:0] row);
        logic [7:0] s;
        case (row)
            3'd1:    s = 8'b0000_0010;
            3'd2:    s = 8'b0001_1000;
            3'd3:    s = 8'b0010_0100;
            3'd4:    s = 8'b0010_0000;
            3'd5:    s = 8'b0010_0100;
            3'd6:    s = 8'b0001_1000;
            default: s = 8'b0000_0000;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] f_percent(input logic [2:0] row);
        logic [7:0] s;
        case (row)
            3'd1:    s = 8'b0010_0000;
            3'd2:    s = 8'b0101_0010;
            3'd3:    s = 8'b0010_0100;
            3'd4:    s = 8'b0000_1000;
            3'd5:    s = 8'b0001_0010;
            3'd6:    s = 8'b0010_0101;
            3'd7:    s = 8'b0000_0010;
            default: s = 8'b0000_0000;
        endcase
        return s;
    endfunction

endpackage

// ===== src/digit_matrix_frame_render.sv =====
// Top level of the digit matrix frame renderer with its result register.
// An accepted request is held in the input register; its row 0 goes to the result register.
// Throughput: one row per cycle while results are taken, set by the single result channel.
// The next request is accepted in the cycle that row 7 moves into the result register.
// Reset clears the row sequencer and the result valid flag; payload registers are not reset.
module digit_matrix_frame_render (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [3:0]  i_month_index,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour_value,
    input  logic [5:0]  i_minute_value,
    input  logic [5:0]  i_second_value,
    input  logic [7:0]  i_humidity_value,
    input  logic [7:0]  i_temperature_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_row_index,
    output logic [31:0] o_row_pixels,
    output logic        o_last_row
);

    dmfr_pkg::t_item in_item;
    dmfr_pkg::t_item held_item;
    dmfr_pkg::t_step step;
    logic [31:0]     row_px;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [2:0]      r_row_index;
    logic [31:0]     r_row_pixels;
    logic            r_last_row;

    always_comb begin
        in_item.command           = i_command;
        in_item.month_index       = i_month_index;
        in_item.day_of_month      = i_day_of_month;
        in_item.hour_value        = i_hour_value;
        in_item.minute_value      = i_minute_value;
        in_item.second_value      = i_second_value;
        in_item.humidity_value    = i_humidity_value;
        in_item.temperature_value = i_temperature_value;
    end

    dmfr_frame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (in_item),
        .i_out_valid (r_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (held_item),
        .o_step      (step)
    );

    dmfr_row_render u_render (
        .i_item   (held_item),
        .i_row    (step.row),
        .o_pixels (row_px)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (step.advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.advance) begin
            r_row_index  <= step.row;
            r_row_pixels <= row_px;
            r_last_row   <= step.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_row_index;
    assign o_row_pixels = r_row_pixels;
    assign o_last_row   = r_last_row;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid set after reset");

    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && step.busy) |-> (step.advance && step.last))
        else $error("request accepted while a frame is still in progress");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_row == (o_row_index == dmfr_pkg::LAST_ROW)))
        else $error("last row flag does not match row index");

    a_frame_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_row) |-> (step.busy && step.row == 3'(o_row_index + 3'd1)))
        else $error("sequencer lost its place within a frame");

endmodule

// ===== src/dmfr_row_render.sv =====
// Combinational renderer of one 32-pixel row from a held request and a row number.
module dmfr_row_render (
    input  dmfr_pkg::t_item i_item,
    input  logic [2:0]      i_row,
    output logic [31:0]     o_pixels
);

    logic [4:0]  mon_next;
    logic [3:0]  mon_ones;
    logic [3:0]  day_tens;
    logic [3:0]  day_ones;
    logic [3:0]  hr_tens;
    logic [3:0]  hr_ones;
    logic [3:0]  mn_tens;
    logic [3:0]  mn_ones;
    logic [6:0]  tmp_mod;
    logic [6:0]  hum_mod;
    logic [2:0]  one_glyph;
    logic [31:0] clock_px;
    logic [31:0] climate_px;

    always_comb begin
        mon_next = {1'b0, i_item.month_index} + 5'd1;
        mon_ones = (mon_next >= 5'd10) ? 4'(mon_next - 5'd10) : mon_next[3:0];
        day_tens = dmfr_pkg::f_div10({2'd0, i_item.day_of_month});
        day_ones = dmfr_pkg::f_mod10({2'd0, i_item.day_of_month});
        hr_tens  = dmfr_pkg::f_div10({2'd0, i_item.hour_value});
        hr_ones  = dmfr_pkg::f_mod10({2'd0, i_item.hour_value});
        mn_tens  = dmfr_pkg::f_div10({1'b0, i_item.minute_value});
        mn_ones  = dmfr_pkg::f_mod10({1'b0, i_item.minute_value});
        tmp_mod  = dmfr_pkg::f_mod100(i_item.temperature_value);
        hum_mod  = dmfr_pkg::f_mod100(i_item.humidity_value);
        one_glyph = dmfr_pkg::f_glyph(4'd1, i_row);

        clock_px = 32'd0;
        if (i_item.month_index > 4'd8) begin
            clock_px[31] = one_glyph[0];
        end
        clock_px[29:27] = dmfr_pkg::f_glyph(mon_ones, i_row);
        clock_px[25:23] = dmfr_pkg::f_glyph(day_tens, i_row);
        clock_px[21:19] = dmfr_pkg::f_glyph(day_ones, i_row);
        clock_px[16:14] = dmfr_pkg::f_glyph(hr_tens, i_row);
        clock_px[12:10] = dmfr_pkg::f_glyph(hr_ones, i_row);
        clock_px[6:4]   = dmfr_pkg::f_glyph(mn_tens, i_row);
        clock_px[2:0]   = dmfr_pkg::f_glyph(mn_ones, i_row);
        if (i_row == dmfr_pkg::DOT_ROW) begin
            clock_px[26] = 1'b1;
        end
        if (i_item.second_value[0]
            && (i_row == dmfr_pkg::COLON_ROW_A || i_row == dmfr_pkg::COLON_ROW_B)) begin
            clock_px[8] = 1'b1;
        end

        climate_px          = 32'd0;
        climate_px[31:29]   = dmfr_pkg::f_glyph(dmfr_pkg::f_div10(tmp_mod), i_row);
        climate_px[27:25]   = dmfr_pkg::f_glyph(dmfr_pkg::f_mod10(tmp_mod), i_row);
        climate_px[23:16]   = dmfr_pkg::f_degree(i_row);
        climate_px[15:13]   = dmfr_pkg::f_glyph(dmfr_pkg::f_div10(hum_mod), i_row);
        climate_px[11:9]    = dmfr_pkg::f_glyph(dmfr_pkg::f_mod10(hum_mod), i_row);
        climate_px[7:0]     = dmfr_pkg::f_percent(i_row);

        o_pixels = (i_item.command == dmfr_pkg::CMD_CLIMATE) ? climate_px : clock_px;
    end

endmodule

// ===== src/dmfr_frame_ctrl.sv =====
// Input register and row sequencer that walks one held request through its eight rows.
module dmfr_frame_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  dmfr_pkg::t_item i_item,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    output dmfr_pkg::t_item o_item,
    output dmfr_pkg::t_step o_step
);

    logic            r_busy;
    logic            n_busy;
    logic [2:0]      r_row;
    logic [2:0]      n_row;
    dmfr_pkg::t_item r_item;
    logic            in_take;

    always_comb begin
        o_step.busy    = r_busy;
        o_step.advance = r_busy && (!i_out_valid || i_out_ready);
        o_step.row     = r_row;
        o_step.last    = (r_row == dmfr_pkg::LAST_ROW);
        o_in_ready     = !r_busy || (o_step.advance && o_step.last);
        in_take        = i_in_valid && o_in_ready;

        n_busy = r_busy;
        n_row  = r_row;
        if (in_take) begin
            n_busy = 1'b1;
            n_row  = 3'd0;
        end else if (o_step.advance) begin
            n_row = r_row + 3'd1;
            if (o_step.last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;

endmodule
